/* rtl/gsbp_pkg.sv */
// Package: shared constants, types and helpers of the gselect predictor.
`timescale 1ns / 1ps

package gsbp_pkg;

  // Default sizing of the predictor.
  localparam int PC_BITS_MAX_DEF   = 8;
  localparam int HIST_BITS_MAX_DEF = 4;
  localparam int COUNT_WIDTH_DEF   = 32;

  // Fixed field widths.
  localparam int ADDR_IN_W   = 64;
  localparam int TOTAL_W     = 32;
  localparam int PC_CFG_W    = 4;
  localparam int HIST_CFG_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  // Register reset values.
  localparam logic [PC_CFG_W-1:0]   PC_BITS_RST   = 4'd8;
  localparam logic [HIST_CFG_W-1:0] HIST_BITS_RST = 3'd4;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // 2-bit counter codes.
  typedef logic [1:0] ctr_t;
  localparam ctr_t CTR_MIN     = 2'd0;
  localparam ctr_t CTR_WEAK_NT = 2'd1;
  localparam ctr_t CTR_MAX     = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PC_BITS   = 2'd0,
    CFG_HIST_BITS = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } bk_state_e;

  // Status from back end to front end.
  typedef struct packed {
    logic clear_busy;
  } bk_status_t;

  // Move a counter one step toward the outcome, saturating.
  function automatic ctr_t ctr_step(ctr_t c, logic t);
    ctr_t r;
    r = c;
    if (t) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

/* rtl/gsbp_if.sv */
// Interfaces: branch input, prediction result and configuration channels.
`timescale 1ns / 1ps

interface gsbp_br_if;
  logic                          valid;
  logic                          ready;
  logic [gsbp_pkg::ADDR_IN_W-1:0] branch_address;
  logic                          taken;

  modport source (output valid, output branch_address, output taken, input ready);
  modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface gsbp_res_if;
  logic                         valid;
  logic                         ready;
  logic                         predicted_taken;
  logic                         correct;
  logic [gsbp_pkg::TOTAL_W-1:0] branch_total;
  logic [gsbp_pkg::TOTAL_W-1:0] miss_total;

  modport source (output valid, output predicted_taken, output correct,
                  output branch_total, output miss_total, input ready);
  modport sink   (input valid, input predicted_taken, input correct,
                  input branch_total, input miss_total, output ready);
endinterface

interface gsbp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gsbp_pkg::CFG_IDX_W-1:0]  index;
  logic [gsbp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/gsbp_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module gsbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gsbp_fifo.sv */
// Short queue between front end and back end.
`timescale 1ns / 1ps

module gsbp_fifo #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import gsbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/gsbp_front.sv */
// Front end: accepts branches, keeps global history, forms the table index.
`timescale 1ns / 1ps

module gsbp_front #(
  parameter int PC_BITS_MAX   = gsbp_pkg::PC_BITS_MAX_DEF,
  parameter int HIST_BITS_MAX = gsbp_pkg::HIST_BITS_MAX_DEF,
  localparam int ADDR_W       = PC_BITS_MAX + HIST_BITS_MAX
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [gsbp_pkg::ADDR_IN_W-1:0]   branch_address_i,
  input  logic                             taken_i,
  input  logic [gsbp_pkg::PC_CFG_W-1:0]    pc_bits_i,
  input  logic [gsbp_pkg::HIST_CFG_W-1:0]  hist_bits_i,
  input  gsbp_pkg::bk_status_t             status_i,
  input  logic                             full_i,
  output logic                             push_o,
  output logic [ADDR_W:0]                  entry_o
);
  import gsbp_pkg::*;

  localparam int PBW = $clog2(PC_BITS_MAX + 1);
  localparam int HBW = $clog2(HIST_BITS_MAX + 1);

  logic [HIST_BITS_MAX-1:0] hist_q, hist_d;
  logic [HIST_BITS_MAX:0]   hist_ext;
  logic [HIST_BITS_MAX-1:0] hist_sel;
  logic [PBW-1:0]           pb;
  logic [HBW-1:0]           hb;
  logic [PC_BITS_MAX-1:0]   pc_field, pc_mask, pc;
  logic [ADDR_W-1:0]        idx;
  logic                     accept;

  // Clamp register widths to the legal range.
  always_comb begin
    if (pc_bits_i == '0) begin
      pb = PBW'(1);
    end else if (32'(pc_bits_i) > PC_BITS_MAX) begin
      pb = PBW'(PC_BITS_MAX);
    end else begin
      pb = PBW'(pc_bits_i);
    end
    if (hist_bits_i == '0) begin
      hb = HBW'(1);
    end else if (32'(hist_bits_i) > HIST_BITS_MAX) begin
      hb = HBW'(HIST_BITS_MAX);
    end else begin
      hb = HBW'(hist_bits_i);
    end
  end

  assign pc_field = branch_address_i[2 +: PC_BITS_MAX];
  assign pc_mask  = ~({PC_BITS_MAX{1'b1}} << pb);
  assign pc       = pc_field & pc_mask;
  assign hist_sel = hist_q >> (HBW'(HIST_BITS_MAX) - hb);
  assign idx      = (ADDR_W'(hist_sel) << pb) | ADDR_W'(pc);

  assign ready_o = !full_i && !status_i.clear_busy;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;
  assign entry_o = {idx, taken_i};

  // Newest outcome enters at the top.
  assign hist_ext = {taken_i, hist_q};
  assign hist_d   = accept ? hist_ext[HIST_BITS_MAX:1] : hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

endmodule

/* rtl/gsbp_back.sv */
// Back end: counter table clear, read-modify-write, statistics, result register.
`timescale 1ns / 1ps

module gsbp_back #(
  parameter int ADDR_W      = 12,
  parameter int COUNT_WIDTH = gsbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  logic [ADDR_W:0]                q_entry_i,
  output logic                           q_pop_o,
  output gsbp_pkg::bk_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           predicted_taken_o,
  output logic                           correct_o,
  output logic [gsbp_pkg::TOTAL_W-1:0]   branch_total_o,
  output logic [gsbp_pkg::TOTAL_W-1:0]   miss_total_o
);
  import gsbp_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  bk_state_e          state_q, state_d;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               taken_q, taken_d;
  logic               out_valid_q, out_valid_d;
  logic               pred_q, pred_d, ok_q, ok_d;
  logic [COUNT_WIDTH-1:0] br_cnt_q, br_cnt_d, miss_cnt_q, miss_cnt_d;
  logic [63:0]        br_ext, miss_ext;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  ctr_t               ram_wdata, ram_rdata;
  logic               slot_free, load_out, pred_now, ok_now;

  gsbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign pred_now  = ram_rdata[1];
  assign ok_now    = (pred_now == taken_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR:  if (clr_addr_q == '1) state_d = BK_IDLE;
      BK_IDLE:   if (q_valid_i) state_d = BK_UPDATE;
      BK_UPDATE: if (slot_free) state_d = BK_IDLE;
      default:   state_d = BK_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ctr_step(ram_rdata, taken_q);
    ram_re    = 1'b0;
    ram_raddr = q_entry_i[ADDR_W:1];
    q_pop_o   = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = CTR_WEAK_NT;
      end
      BK_IDLE: begin
        ram_re  = q_valid_i;
        q_pop_o = q_valid_i;
      end
      BK_UPDATE: begin
        ram_we   = slot_free;
        load_out = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_addr_d  = (state_q == BK_CLEAR) ? clr_addr_q + ADDR_W'(1) : clr_addr_q;
    idx_d       = q_pop_o ? q_entry_i[ADDR_W:1] : idx_q;
    taken_d     = q_pop_o ? q_entry_i[0] : taken_q;
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    pred_d      = load_out ? pred_now : pred_q;
    ok_d        = load_out ? ok_now : ok_q;
    br_cnt_d    = br_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    if (load_out) begin
      if (br_cnt_q != '1) br_cnt_d = br_cnt_q + COUNT_WIDTH'(1);
      if (!ok_now && miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      br_cnt_q    <= '0;
      miss_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      br_cnt_q    <= br_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    taken_q <= taken_d;
    pred_q  <= pred_d;
    ok_q    <= ok_d;
  end

  assign br_ext   = 64'(br_cnt_q);
  assign miss_ext = 64'(miss_cnt_q);

  assign status_o.clear_busy = (state_q == BK_CLEAR);
  assign out_valid_o         = out_valid_q;
  assign predicted_taken_o   = pred_q;
  assign correct_o           = ok_q;
  assign branch_total_o      = br_ext[TOTAL_W-1:0];
  assign miss_total_o        = miss_ext[TOTAL_W-1:0];

endmodule

/* rtl/gselect_branch_predictor.sv */
// Top level of the gselect branch predictor with 2-bit saturating counters.
`timescale 1ns / 1ps

// Gselect predictor. Each transaction on br_i is one resolved branch; it
// yields one transaction on res_o with the prediction made before update,
// whether it was right, and saturating totals of branches and misses. The
// table index is {history top hist_bits, (addr >> 2) low pc_bits}; the
// history shifts the new outcome in at its top. The back end takes one
// branch at a time from the queue: a registered read of the single counter
// RAM, then the write of the moved counter, held while the result is stalled.
// A result passes through the queue, the table read and the result register.
// After reset the back end sweeps the table to weakly-not-taken, one entry
// a cycle, over all 2^(PC_BITS_MAX+HIST_BITS_MAX) entries (4096 by default), during
// which br_i.ready stays low. cfg_i is always ready; write pc_bits (index 0)
// and hist_bits (index 1) only while idle. Out-of-range values clamp to
// 1..PC_BITS_MAX and 1..HIST_BITS_MAX; unknown indexes are ignored.
module gselect_branch_predictor #(
  parameter int PC_BITS_MAX   = gsbp_pkg::PC_BITS_MAX_DEF,
  parameter int HIST_BITS_MAX = gsbp_pkg::HIST_BITS_MAX_DEF,
  parameter int COUNT_WIDTH   = gsbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gsbp_br_if.sink          br_i,
  gsbp_res_if.source       res_o,
  gsbp_cfg_if.sink         cfg_i
);
  import gsbp_pkg::*;

  localparam int ADDR_W = PC_BITS_MAX + HIST_BITS_MAX;

  logic [PC_CFG_W-1:0]   pc_bits_q, pc_bits_d;
  logic [HIST_CFG_W-1:0] hist_bits_q, hist_bits_d;

  bk_status_t    status;
  logic          push, full, q_valid, q_pop;
  logic [ADDR_W:0] push_entry, q_entry;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    pc_bits_d   = pc_bits_q;
    hist_bits_d = hist_bits_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_PC_BITS:   pc_bits_d   = cfg_i.data[PC_CFG_W-1:0];
        CFG_HIST_BITS: hist_bits_d = cfg_i.data[HIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_bits_q   <= PC_BITS_RST;
      hist_bits_q <= HIST_BITS_RST;
    end else begin
      pc_bits_q   <= pc_bits_d;
      hist_bits_q <= hist_bits_d;
    end
  end

  // Front end: history and index formation.
  gsbp_front #(
    .PC_BITS_MAX   (PC_BITS_MAX),
    .HIST_BITS_MAX (HIST_BITS_MAX)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (br_i.valid),
    .ready_o          (br_i.ready),
    .branch_address_i (br_i.branch_address),
    .taken_i          (br_i.taken),
    .pc_bits_i        (pc_bits_q),
    .hist_bits_i      (hist_bits_q),
    .status_i         (status),
    .full_i           (full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  // Queue of {index, outcome}.
  gsbp_fifo #(
    .WIDTH (ADDR_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  // Back end: counter table update and result.
  gsbp_back #(
    .ADDR_W      (ADDR_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_entry_i         (q_entry),
    .q_pop_o           (q_pop),
    .status_o          (status),
    .out_valid_o       (res_o.valid),
    .out_ready_i       (res_o.ready),
    .predicted_taken_o (res_o.predicted_taken),
    .correct_o         (res_o.correct),
    .branch_total_o    (res_o.branch_total),
    .miss_total_o      (res_o.miss_total)
  );

endmodule

/* rtl/gsbp_checker.sv */
// Checker: port-level assertions on the gselect predictor, bound to the top.
`timescale 1ns / 1ps

module gsbp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_pred,
  input logic                         res_correct,
  input logic [gsbp_pkg::TOTAL_W-1:0] res_branch_total,
  input logic [gsbp_pkg::TOTAL_W-1:0] res_miss_total,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);
  import gsbp_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_pred) && $stable(res_correct)
      && $stable(res_branch_total) && $stable(res_miss_total))
    else $error("result payload changed while stalled");

  a_miss_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_miss_total <= res_branch_total)
    else $error("miss total exceeds branch total");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_branch_total != '0)
    else $error("result shows zero branches");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind gselect_branch_predictor gsbp_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid        (res_o.valid),
  .res_ready        (res_o.ready),
  .res_pred         (res_o.predicted_taken),
  .res_correct      (res_o.correct),
  .res_branch_total (res_o.branch_total),
  .res_miss_total   (res_o.miss_total),
  .cfg_valid        (cfg_i.valid),
  .cfg_ready        (cfg_i.ready)
);

/* tb/sv/testbench.sv */
// Self-checking testbench of the gselect branch predictor with its own predictor.
`timescale 1ns / 1ps

module testbench;
  import gsbp_pkg::*;

  // Pattern history table covers every index the widest setting can form.
  localparam int PHT_DEPTH = 1 << (PC_BITS_MAX_DEF + HIST_BITS_MAX_DEF);

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  // Counter value at and above which the block predicts taken.
  localparam ctr_t CTR_WEAK_T = 2'd2;

  localparam int DRAIN_CYCLES = 8;     // extra wait after the last result, as margin
  localparam int HOLD_CYCLES  = 200;   // long receiver stall
  localparam int PHASE_ITEMS  = 200;
  localparam int LIMIT_NS     = 5_000_000;

  // How a hot branch of the random phases tends to resolve.
  typedef enum int unsigned {
    LEAN_NOT_TAKEN,
    LEAN_TAKEN,
    ALTERNATING,
    LOOP_EXIT
  } habit_e;

  typedef struct {
    logic [ADDR_IN_W-1:0] addr;
    logic                 taken;
    int unsigned          gap;        // idle cycles before it is offered
  } stim_item_t;

  typedef struct {
    logic               pred;
    logic               correct;
    logic [TOTAL_W-1:0] branches;
    logic [TOTAL_W-1:0] misses;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gsbp_br_if  br ();
  gsbp_res_if res ();
  gsbp_cfg_if cfg ();

  gselect_branch_predictor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .br_i   (br),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state, kept apart from the block
  // ---------------------------------------------------------------------------
  ctr_t                          pht [PHT_DEPTH];
  logic [HIST_BITS_MAX_DEF-1:0]  ghist;
  logic [TOTAL_W-1:0]            n_branch;
  logic [TOTAL_W-1:0]            n_miss;
  logic [PC_CFG_W-1:0]           pc_bits_q;
  logic [HIST_CFG_W-1:0]         hist_bits_q;

  stim_item_t to_send [$];   // branches waiting for the driver
  verdict_t   due [$];       // predictions owed by the block, oldest first

  bit          idle_on    = 1'b1;
  logic        br_fire    = 1'b0;
  logic        res_fire   = 1'b0;
  int unsigned src_wait   = 0;
  int unsigned snk_wait   = 0;
  int unsigned hold_left  = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_writes   = 0;
  int unsigned errors     = 0;

  // Register values outside 1..max act as the nearest end of the range.
  function automatic int unsigned eff_width(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Looks up the counter for one resolved branch, trains it, shifts the
  // outcome into the history and bumps the totals. Returns what the block owes.
  function automatic verdict_t resolve_branch(logic [ADDR_IN_W-1:0] addr, logic t);
    verdict_t    v;
    int unsigned pb;
    int unsigned hb;
    int unsigned pc;
    int unsigned hsel;
    int unsigned idx;
    ctr_t        c;
    pb   = eff_width(32'(pc_bits_q), PC_BITS_MAX_DEF);
    hb   = eff_width(32'(hist_bits_q), HIST_BITS_MAX_DEF);
    pc   = int'(addr[2 +: PC_BITS_MAX_DEF]) & ((1 << pb) - 1);
    hsel = int'(ghist) >> (HIST_BITS_MAX_DEF - hb);   // top hb history bits
    idx  = ((hsel << pb) | pc) & (PHT_DEPTH - 1);
    c    = pht[idx];
    v.pred    = (c >= CTR_WEAK_T);
    v.correct = (v.pred == t);
    if (t) begin
      if (c != CTR_MAX) c = c + 2'd1;
    end else begin
      if (c != CTR_MIN) c = c - 2'd1;
    end
    pht[idx] = c;
    ghist = {t, ghist[HIST_BITS_MAX_DEF-1:1]};
    if (n_branch != '1) n_branch = n_branch + 1'b1;
    if (!v.correct && n_miss != '1) n_miss = n_miss + 1'b1;
    v.branches = n_branch;
    v.misses   = n_miss;
    return v;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one; none when idle_on is clear.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: branch transactions, fed from to_send
  // ---------------------------------------------------------------------------
  // Acceptance is taken at the rising edge; the expectation is computed from
  // exactly the payload that was on the channel at that edge.
  always @(posedge clk_i) begin
    br_fire <= rst_ni && br.valid && br.ready;
    if (rst_ni && br.valid && br.ready) begin
      due.push_back(resolve_branch(br.branch_address, br.taken));
      n_accepted++;
    end
  end

  // A branch stays on the channel until accepted; the next one goes up right
  // after, unless its gap says to idle first. valid gets a single NBA per step.
  always @(negedge clk_i) begin : drive_branches
    stim_item_t nxt;
    if (!(br.valid && !br_fire)) begin
      if (to_send.size() != 0 && src_wait >= to_send[0].gap) begin
        nxt = to_send.pop_front();
        br.valid          <= 1'b1;
        br.branch_address <= nxt.addr;
        br.taken          <= nxt.taken;
        src_wait = 0;
      end else begin
        br.valid <= 1'b0;
        if (to_send.size() != 0) src_wait++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result transactions, checked against due
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    res_fire <= rst_ni && res.valid && res.ready;
    if (rst_ni && res.valid && res.ready) begin
      n_checked++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected (pred %0b, correct %0b, %0d/%0d)",
                 $time, res.predicted_taken, res.correct, res.branch_total, res.miss_total);
      end else begin
        want = due.pop_front();
        if (res.predicted_taken !== want.pred) begin
          errors++;
          $display("%0t: predicted_taken expected %0b, got %0b",
                   $time, want.pred, res.predicted_taken);
        end
        if (res.correct !== want.correct) begin
          errors++;
          $display("%0t: correct expected %0b, got %0b", $time, want.correct, res.correct);
        end
        if (res.branch_total !== want.branches) begin
          errors++;
          $display("%0t: branch_total expected %0d, got %0d",
                   $time, want.branches, res.branch_total);
        end
        if (res.miss_total !== want.misses) begin
          errors++;
          $display("%0t: miss_total expected %0d, got %0d",
                   $time, want.misses, res.miss_total);
        end
      end
    end
  end

  // Receiver pacing. Twice in the run the receiver goes deaf for a long
  // stretch while the driver keeps offering, so the internal queue fills and
  // br_i.ready has to drop.
  always @(negedge clk_i) begin
    if (res_fire && (n_checked == 300 || n_checked == 900)) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      if (res_fire) snk_wait = pick_gap();
      if (snk_wait != 0) begin
        snk_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(posedge clk_i); while (!cfg.ready);
    // Only the bits each register holds survive the write.
    if (idx == CFG_PC_BITS) pc_bits_q = val;
    else if (idx == CFG_HIST_BITS) hist_bits_q = val[HIST_CFG_W-1:0];
    n_writes++;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic set_widths(input logic [CFG_DATA_W-1:0] pcw, input logic [CFG_DATA_W-1:0] hw);
    write_reg(CFG_PC_BITS, pcw);
    write_reg(CFG_HIST_BITS, hw);
  endtask

  task automatic queue_branch(input logic [ADDR_IN_W-1:0] addr, input logic t);
    stim_item_t b;
    b.addr  = addr;
    b.taken = t;
    b.gap   = pick_gap();
    to_send.push_back(b);
  endtask

  // Sender pause: nothing queued, nothing on the channel, nothing owed.
  task automatic wait_drained();
    while (to_send.size() != 0 || br.valid || due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a handful of hot branches with steady habits, so counters saturate
  // and history patterns repeat; the rest are cold branches at any address.
  task automatic run_random(input int n, input bit idle);
    logic [ADDR_IN_W-1:0] pool [8];
    habit_e               habit [8];
    int unsigned          visits [8];
    int unsigned          k;
    logic                 t;
    idle_on = idle;
    for (int i = 0; i < 8; i++) begin
      pool[i]   = {$urandom, $urandom};
      habit[i]  = habit_e'($urandom_range(3));
      visits[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(7);
        case (habit[k])
          LEAN_NOT_TAKEN: t = ($urandom_range(9) == 0);
          LEAN_TAKEN:     t = ($urandom_range(9) != 0);
          ALTERNATING:    t = visits[k][0];
          default:        t = (visits[k] % 4 != 3);
        endcase
        visits[k]++;
        queue_branch(pool[k], t);
      end else begin
        queue_branch({$urandom, $urandom}, 1'($urandom_range(1)));
      end
    end
    wait_drained();
  endtask

  initial begin
    br.valid          = 1'b0;
    br.branch_address = '0;
    br.taken          = 1'b0;
    res.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = CFG_PC_BITS;
    cfg.data          = '0;
    for (int i = 0; i < PHT_DEPTH; i++) pht[i] = CTR_WEAK_NT;
    ghist       = '0;
    n_branch    = '0;
    n_miss      = '0;
    pc_bits_q   = PC_BITS_RST;
    hist_bits_q = HIST_BITS_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset widths. The block sweeps its table first;
    // the driver simply waits on br_i.ready through that.
    idle_on = 1'b1;
    queue_branch('0, 1'b0);
    queue_branch('1, 1'b1);
    queue_branch(64'h3, 1'b1);                      // byte offset bits are not part of pc
    queue_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_branch(64'h5555_5555_5555_5555, 1'b1);
    // One branch resolved taken six times in a row, then not taken six times.
    repeat (6) queue_branch(64'h1000, 1'b1);
    repeat (6) queue_branch(64'h1000, 1'b0);
    queue_branch(64'hFFFF_FFFF_0000_0000, 1'b1);
    queue_branch(64'h0000_0000_FFFF_FFFC, 1'b0);
    wait_drained();

    // Zero widths act as one bit each.
    set_widths(4'd0, 4'd0);
    run_random(PHASE_ITEMS, 1'b1);

    // Values above the maximum act as the maximum.
    set_widths(4'd15, 4'd7);
    run_random(PHASE_ITEMS, 1'b1);

    // Smallest legal widths; writes to undecoded indexes change nothing.
    set_widths(4'd1, 4'd1);
    write_reg(CFG_IDX_SPARE_A, 4'($urandom_range(15)));
    write_reg(CFG_IDX_SPARE_B, 4'($urandom_range(15)));
    run_random(PHASE_ITEMS, 1'b0);

    // hist_bits keeps only its three low bits: 4'hF reads as 7, then clamps.
    set_widths(4'd8, 4'hF);
    run_random(PHASE_ITEMS, 1'b1);

    set_widths(4'd3, 4'd2);
    run_random(PHASE_ITEMS, 1'b1);

    set_widths(4'd5, 4'd3);
    run_random(PHASE_ITEMS, 1'b0);

    set_widths(4'($urandom_range(15)), 4'($urandom_range(15)));
    run_random(PHASE_ITEMS, 1'b1);

    repeat (20) @(posedge clk_i);
    if (due.size() != 0) begin
      errors++;
      $display("%0t: %0d predictions never came out", $time, due.size());
    end

    $display("Covered %0d resolved branches, %0d results checked, %0d mispredicted,",
             n_accepted, n_checked, n_miss);
    $display("across %0d register writes with widths from clamped-low to clamped-high.",
             n_writes);
    if (errors == 0) begin
      $display("** gselect_branch_predictor: PASSED **");
    end else begin
      $display("** gselect_branch_predictor: FAILED **");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run (table sweep plus about
  // 1400 branches with the longest gaps and stalls on both sides).
  initial begin
    #(LIMIT_NS);
    $display("Timed out at %0t with %0d predictions outstanding", $time, due.size());
    $display("** gselect_branch_predictor: FAILED **");
    $finish;
  end

endmodule
